>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define VPPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define VPPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/vpps_pkg.sv
// ---------------------------------------------------------------------------
// vpps_pkg
// Types and constants shared by the velocity/position PI step unit.
// ---------------------------------------------------------------------------
package vpps_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PerW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivCntW = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VEL_PROP_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VEL_INT_GAIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_POS_GAIN      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD        = 2'd3;

  localparam logic [DivCntW-1:0] DIV_LAST = 5'd31;

  // Action codes carried in each input beat.
  typedef enum logic [1:0] {
    ACT_VEL   = 2'd0,
    ACT_POS   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_POS,
    OP_ERR,
    OP_DIV,
    OP_FIX,
    OP_MULP,
    OP_MULI,
    OP_SUM,
    OP_HALF,
    OP_SCALE,
    OP_CLEAR,
    OP_ZERO,
    OP_PUSH
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POS,
    ST_ERR,
    ST_DIV,
    ST_FIX,
    ST_MULP,
    ST_MULI,
    ST_SUM,
    ST_HALF,
    ST_SCALE,
    ST_CLEAR,
    ST_ZERO,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/vpps_chan_if.sv
// ---------------------------------------------------------------------------
// vpps channel interfaces
// Valid/ready channels for the input items and the result items.
// ---------------------------------------------------------------------------
interface vpps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] target;
  logic signed [31:0] measured;

  modport source (output valid, output action, output target, output measured,
                  input ready);
  modport sink   (input valid, input action, input target, input measured,
                  output ready);
endinterface

interface vpps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

>>> hw/rtl/vpps_ctrl.sv
// ---------------------------------------------------------------------------
// vpps_ctrl
// Sequencer that walks one item through the datapath operations.
// ---------------------------------------------------------------------------
module vpps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpps_pkg::dp_stat_t stat_i,
  output vpps_pkg::dp_cmd_t  cmd_o
);

  vpps_pkg::state_e                    state_q, state_d;
  logic [vpps_pkg::DivCntW-1:0]        cnt_q, cnt_d;

  // State and divide step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vpps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.op    = vpps_pkg::OP_NONE;
    unique case (state_q)
      vpps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = vpps_pkg::ST_DECODE;
        end
      end
      vpps_pkg::ST_DECODE: begin
        unique case (stat_i.action)
          vpps_pkg::ACT_VEL:   state_d = vpps_pkg::ST_ERR;
          vpps_pkg::ACT_POS:   state_d = vpps_pkg::ST_POS;
          vpps_pkg::ACT_CLEAR: state_d = vpps_pkg::ST_CLEAR;
          vpps_pkg::ACT_RSVD:  state_d = vpps_pkg::ST_ZERO;
        endcase
      end
      vpps_pkg::ST_POS: begin
        cmd_o.op = vpps_pkg::OP_POS;
        state_d  = vpps_pkg::ST_ERR;
      end
      vpps_pkg::ST_ERR: begin
        cmd_o.op = vpps_pkg::OP_ERR;
        cnt_d    = '0;
        state_d  = vpps_pkg::ST_DIV;
      end
      vpps_pkg::ST_DIV: begin
        cmd_o.op = vpps_pkg::OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == vpps_pkg::DIV_LAST) begin
          state_d = vpps_pkg::ST_FIX;
        end
      end
      vpps_pkg::ST_FIX: begin
        cmd_o.op = vpps_pkg::OP_FIX;
        state_d  = vpps_pkg::ST_MULP;
      end
      vpps_pkg::ST_MULP: begin
        cmd_o.op = vpps_pkg::OP_MULP;
        state_d  = vpps_pkg::ST_MULI;
      end
      vpps_pkg::ST_MULI: begin
        cmd_o.op = vpps_pkg::OP_MULI;
        state_d  = vpps_pkg::ST_SUM;
      end
      vpps_pkg::ST_SUM: begin
        cmd_o.op = vpps_pkg::OP_SUM;
        state_d  = vpps_pkg::ST_HALF;
      end
      vpps_pkg::ST_HALF: begin
        cmd_o.op = vpps_pkg::OP_HALF;
        state_d  = vpps_pkg::ST_SCALE;
      end
      vpps_pkg::ST_SCALE: begin
        cmd_o.op = vpps_pkg::OP_SCALE;
        state_d  = vpps_pkg::ST_PUSH;
      end
      vpps_pkg::ST_CLEAR: begin
        cmd_o.op = vpps_pkg::OP_CLEAR;
        state_d  = vpps_pkg::ST_PUSH;
      end
      vpps_pkg::ST_ZERO: begin
        cmd_o.op = vpps_pkg::OP_ZERO;
        state_d  = vpps_pkg::ST_PUSH;
      end
      vpps_pkg::ST_PUSH: begin
        // Wait until the output register can take the result.
        if (stat_i.out_free) begin
          cmd_o.op = vpps_pkg::OP_PUSH;
          state_d  = vpps_pkg::ST_IDLE;
        end
      end
      default: state_d = vpps_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/vpps_dp.sv
// ---------------------------------------------------------------------------
// vpps_dp
// Datapath: configuration, history, shared multiplier, serial divider and
// the output register.
// ---------------------------------------------------------------------------
module vpps_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vpps_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [vpps_pkg::DataW-1:0]          cfg_wdata_i,
  input  logic [1:0]                          in_action_i,
  input  logic signed [vpps_pkg::DataW-1:0]   in_target_i,
  input  logic signed [vpps_pkg::DataW-1:0]   in_measured_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vpps_pkg::DataW-1:0]   out_drive_o,
  input  vpps_pkg::dp_cmd_t                   cmd_i,
  output vpps_pkg::dp_stat_t                  stat_o
);

  // Configuration registers.
  logic [vpps_pkg::DataW-1:0] kp_q, ki_q, kpos_q;
  logic [vpps_pkg::PerW-1:0]  per_q;

  // Item and history registers.
  vpps_pkg::action_e          act_q;
  logic [vpps_pkg::DataW-1:0] tgt_q, meas_q, e_q;
  logic [vpps_pkg::DataW-1:0] prev_err_q, prev_dlt_q;
  logic [vpps_pkg::DataW-1:0] quo_q, prod_q, du_q, res_q;
  logic [vpps_pkg::PerW-1:0]  rem_q;
  logic                       neg_q;
  logic                       out_vld_q;
  logic [vpps_pkg::DataW-1:0] out_drv_q;

  logic [vpps_pkg::DataW-1:0] mul_a, mul_b, product;
  logic [vpps_pkg::DataW-1:0] err, diff, sum, sum_rnd;
  logic [vpps_pkg::PerW:0]    trial;
  logic                       fits;
  logic                       out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kpos_q <= '0;
      per_q  <= vpps_pkg::PerW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vpps_pkg::CFG_VEL_PROP_GAIN: kp_q   <= cfg_wdata_i;
        vpps_pkg::CFG_VEL_INT_GAIN:  ki_q   <= cfg_wdata_i;
        vpps_pkg::CFG_POS_GAIN:      kpos_q <= cfg_wdata_i;
        vpps_pkg::CFG_PERIOD:        per_q  <= cfg_wdata_i[vpps_pkg::PerW-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier, low word of the product only.
  always_comb begin
    mul_a = kp_q;
    mul_b = quo_q;
    case (cmd_i.op)
      vpps_pkg::OP_POS: begin
        mul_a = kpos_q;
        mul_b = tgt_q - meas_q;
      end
      vpps_pkg::OP_MULI: begin
        mul_a = ki_q;
        mul_b = e_q;
      end
      vpps_pkg::OP_SCALE: begin
        mul_a = res_q;
        mul_b = {{(vpps_pkg::DataW-vpps_pkg::PerW){1'b0}}, per_q};
      end
      default: ;
    endcase
  end
  assign product = mul_a * mul_b;

  // Error terms and one restoring divide step.
  assign err     = tgt_q - meas_q;
  assign diff    = err - prev_err_q;
  assign trial   = {rem_q, quo_q[vpps_pkg::DataW-1]};
  assign fits    = trial >= {1'b0, per_q};
  // Halving truncated toward zero: add one before the shift when negative.
  assign sum     = du_q + prev_dlt_q;
  assign sum_rnd = sum + {{(vpps_pkg::DataW-1){1'b0}}, sum[vpps_pkg::DataW-1]};
  assign out_free = !out_vld_q || out_ready_i;

  // Item sequencing registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= vpps_pkg::action_e'(in_action_i);
      tgt_q  <= in_target_i;
      meas_q <= in_measured_i;
    end
    case (cmd_i.op) inside
      vpps_pkg::OP_POS: meas_q <= product;
      vpps_pkg::OP_ERR: begin
        e_q   <= err;
        neg_q <= diff[vpps_pkg::DataW-1];
        quo_q <= diff[vpps_pkg::DataW-1] ? (~diff + 1'b1) : diff;
        rem_q <= '0;
      end
      vpps_pkg::OP_DIV: begin
        rem_q <= fits ? trial[vpps_pkg::PerW-1:0] - per_q : trial[vpps_pkg::PerW-1:0];
        quo_q <= {quo_q[vpps_pkg::DataW-2:0], fits};
      end
      vpps_pkg::OP_FIX: begin
        if (per_q == '0) begin
          quo_q <= '0;
        end else if (neg_q) begin
          quo_q <= ~quo_q + 1'b1;
        end
      end
      vpps_pkg::OP_MULP: prod_q <= product;
      vpps_pkg::OP_MULI: begin
        du_q   <= prod_q;
        prod_q <= product;
      end
      vpps_pkg::OP_SUM:  du_q  <= du_q + prod_q;
      vpps_pkg::OP_HALF: res_q <= {sum_rnd[vpps_pkg::DataW-1], sum_rnd[vpps_pkg::DataW-1:1]};
      vpps_pkg::OP_SCALE: res_q <= product;
      vpps_pkg::OP_CLEAR, vpps_pkg::OP_ZERO: res_q <= '0;
      default: ;
    endcase
  end

  // Controller history, cleared by reset and by the clear action.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      prev_dlt_q <= '0;
    end else if (cmd_i.op == vpps_pkg::OP_SCALE) begin
      prev_err_q <= e_q;
      prev_dlt_q <= du_q;
    end else if (cmd_i.op == vpps_pkg::OP_CLEAR) begin
      prev_err_q <= '0;
      prev_dlt_q <= '0;
    end
  end

  // Output register: holds one finished result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.op == vpps_pkg::OP_PUSH) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vpps_pkg::OP_PUSH) begin
      out_drv_q <= res_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_drive_o     = out_drv_q;
  assign stat_o.action   = act_q;
  assign stat_o.out_free = out_free;

endmodule

>>> hw/rtl/velocity_position_pi_step_unit.sv
// ---------------------------------------------------------------------------
// velocity_position_pi_step_unit
// Velocity-form PI controller step with an optional position outer gain.
// ---------------------------------------------------------------------------
// Usage:
// Input beats on in_i carry an action, a target and a measurement. Each
// accepted beat yields exactly one beat on out_o carrying the drive value.
// Gains and the period are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the unit is idle; a write takes effect at the next clock edge.
// The error change comes from a restoring divider; the products share one
// multiplier. One item is in work at a time: in_i.ready is high only while
// the sequencer is idle, so a new item is taken only once the last result
// has gone into the output register.
// A finished result sits in an output register; a new input beat is taken
// while that result still waits. If the sink stalls, the next result waits
// in the sequencer until the register frees up.
// Reset clears the history, sets gains to zero and the period to one, and
// drops any pending output beat.
// ---------------------------------------------------------------------------
module velocity_position_pi_step_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vpps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vpps_pkg::DataW-1:0]   cfg_wdata_i,
  vpps_in_if.sink                      in_i,
  vpps_out_if.source                   out_o
);

  vpps_pkg::dp_cmd_t  cmd;
  vpps_pkg::dp_stat_t stat;
  logic               in_ready;

  // Sequencer.
  vpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  vpps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_action_i   (in_i.action),
    .in_target_i   (in_i.target),
    .in_measured_i (in_i.measured),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_drive_o   (out_o.drive),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  assign in_i.ready = in_ready;

endmodule

>>> hw/rtl/vpps_checker.sv
// ---------------------------------------------------------------------------
// vpps_checker
// Port-level assertions for the PI step unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vpps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_drive_i
);

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result beat stays put with its value.
  `VPPS_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i)
  `VPPS_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_drive_i))
  // Only one item is in work: no second beat right after an accepted one.
  `VPPS_ASSERT_NEXT(a_one_item, in_beat, !in_ready_i)
  // Even the shortest item cannot raise its result beat right after it is accepted.
  `VPPS_ASSERT_NEXT(a_min_latency, in_beat, !$rose(out_valid_i))

endmodule

bind velocity_position_pi_step_unit vpps_checker u_vpps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_drive_i (out_o.drive)
);

>>> test/vpps_drive_checker.sv
// ---------------------------------------------------------------------------
// vpps_drive_checker
// Watches the configuration port and both channels of the PI step unit. It
// keeps its own copy of the gains, the period and the error history, predicts
// the drive of every accepted input beat and compares it with the output beats
// in order.
// ---------------------------------------------------------------------------
module vpps_drive_checker
  import vpps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  vpps_in_if                 in_mon,
  vpps_out_if                out_mon,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [DataW-1:0] prop_gain_r;
  logic [DataW-1:0] int_gain_r;
  logic [DataW-1:0] pos_gain_r;
  logic [PerW-1:0]  period_r;

  // Shadow copy of the controller history.
  logic [DataW-1:0] hist_err;
  logic [DataW-1:0] hist_incr;

  // Drive values still owed by the unit, oldest first.
  logic [DataW-1:0] drive_owed_q[$];
  int unsigned      fail_cnt;
  int unsigned      owed_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = owed_cnt;

  // Signed dividend over an unsigned divisor, truncated toward zero.
  // A zero divisor gives a zero quotient.
  function automatic logic [DataW-1:0] div_toward_zero(logic [DataW-1:0] num,
                                                       logic [DataW-1:0] den);
    longint      n;
    longint      d;
    logic [63:0] q;
    if (den == '0) begin
      return '0;
    end
    n = longint'($signed(num));
    d = den;
    q = n / d;
    return q[DataW-1:0];
  endfunction

  // One velocity step: updates the history and returns the drive.
  function automatic logic [DataW-1:0] vel_update(logic [DataW-1:0] tgt,
                                                  logic [DataW-1:0] meas);
    logic [DataW-1:0] err;
    logic [DataW-1:0] err_chg;
    logic [DataW-1:0] incr;
    logic [DataW-1:0] half;
    logic [DataW-1:0] per;
    per     = {{(DataW-PerW){1'b0}}, period_r};
    err     = tgt - meas;
    err_chg = div_toward_zero(err - hist_err, per);
    incr    = prop_gain_r * err_chg + int_gain_r * err;
    half    = div_toward_zero(incr + hist_incr, 32'd2);
    hist_incr = incr;
    hist_err  = err;
    return half * per;
  endfunction

  // Everything is sampled at the rising edge; stimulus moves on the falling one.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [DataW-1:0] want;
    if (!rst_ni) begin
      prop_gain_r = '0;
      int_gain_r  = '0;
      pos_gain_r  = '0;
      period_r    = PerW'(1);
      hist_err    = '0;
      hist_incr   = '0;
      drive_owed_q.delete();
      fail_cnt    = 0;
      owed_cnt    = 0;
    end else begin
      // Register writes only happen while the unit is idle.
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CFG_VEL_PROP_GAIN: prop_gain_r = cfg_wdata_i;
          CFG_VEL_INT_GAIN:  int_gain_r  = cfg_wdata_i;
          CFG_POS_GAIN:      pos_gain_r  = cfg_wdata_i;
          CFG_PERIOD:        period_r    = cfg_wdata_i[PerW-1:0];
          default: ;
        endcase
      end

      // Output beat: compare with the oldest owed drive.
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (drive_owed_q.size() == 0) begin
          $error("drive: no beat expected, actual %0d", $signed(out_mon.drive));
          fail_cnt++;
        end else begin
          want = drive_owed_q.pop_front();
          if (out_mon.drive !== want) begin
            $error("drive mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(out_mon.drive));
            fail_cnt++;
          end
        end
      end

      // Input beat: every action owes exactly one drive.
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        case (in_mon.action)
          ACT_VEL: want = vel_update(in_mon.target, in_mon.measured);
          ACT_POS: want = vel_update(in_mon.target,
                                     pos_gain_r * (in_mon.target - in_mon.measured));
          ACT_CLEAR: begin
            hist_err  = '0;
            hist_incr = '0;
            want      = '0;
          end
          default: want = '0;
        endcase
        drive_owed_q.push_back(want);
      end

      owed_cnt = drive_owed_q.size();
    end
  end

endmodule

>>> test/velocity_position_pi_step_unit_tb.sv
// ---------------------------------------------------------------------------
// velocity_position_pi_step_unit_tb
// Drives the PI step unit through a directed set of corner items and then
// about 1600 random items over several gain and period settings, with random
// gaps on the input side and random stalls on the output side. A separate
// checker predicts each drive and counts mismatches.
// ---------------------------------------------------------------------------
module velocity_position_pi_step_unit_tb;
  import vpps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned DrainWait  = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending;
  logic        in_fire;
  logic        out_fire;
  logic        no_idle;

  vpps_in_if  in_ch ();
  vpps_out_if out_ch ();

  velocity_position_pi_step_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  vpps_drive_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 20 ns clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Handshake flags, captured at the rising edge and read at the falling one.
  always @(posedge clk_i) begin
    in_fire  <= (in_ch.valid && in_ch.ready) === 1'b1;
    out_fire <= (out_ch.valid && out_ch.ready) === 1'b1;
  end

  // Number of idle cycles before the next beat on either side.
  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(6, 0);
  endfunction

  // Mostly small values so the controller math stays readable, plus full
  // range words and the extremes.
  function automatic logic [DataW-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      return DataW'($urandom_range(4000, 0)) - 32'd2000;
    end else if (pick < 85) begin
      return $urandom();
    end else begin
      case ($urandom_range(3, 0))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
  endfunction

  function automatic logic [DataW-1:0] rand_gain();
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return DataW'($urandom_range(15, 0));
    endcase
  endfunction

  // One register write, starting and ending on a falling edge. The caller
  // drops the write enable after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Period writes also carry random upper bits, which the unit drops.
  task automatic write_all(logic [DataW-1:0] kp, logic [DataW-1:0] ki,
                           logic [DataW-1:0] kpos, logic [PerW-1:0] per);
    write_reg(CFG_VEL_PROP_GAIN, kp);
    write_reg(CFG_VEL_INT_GAIN, ki);
    write_reg(CFG_POS_GAIN, kpos);
    write_reg(CFG_PERIOD, {PerW'($urandom()), per});
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending and wait until every owed drive has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Present one input beat and return on the falling edge after it is taken.
  task automatic send_item(action_e act, logic [DataW-1:0] tgt,
                           logic [DataW-1:0] meas);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.target   <= tgt;
    in_ch.measured <= meas;
    do begin
      @(negedge clk_i);
    end while (!in_fire);
  endtask

  task automatic send_random();
    int unsigned pick;
    action_e     act;
    pick = $urandom_range(99, 0);
    if (pick < 50) begin
      act = ACT_VEL;
    end else if (pick < 85) begin
      act = ACT_POS;
    end else if (pick < 93) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_RSVD;
    end
    send_item(act, rand_word(), rand_word());
  endtask

  // Output side: a random stall before each result beat.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
      end while (!out_fire);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [PerW-1:0] per;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_VEL;
    in_ch.target   = '0;
    in_ch.measured = '0;
    no_idle        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: zero gains give a zero drive.
    send_item(ACT_VEL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_POS, 32'h8000_0000, 32'h7FFF_FFFF);

    // Small gains, unit period: wraps, sign handling and odd halving.
    wait_idle();
    write_all(32'd3, 32'd1, 32'd2, 16'd1);
    send_item(ACT_VEL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_VEL, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_VEL, 32'd0, 32'd0);
    send_item(ACT_VEL, -32'sd7, 32'd0);
    send_item(ACT_POS, 32'd100, -32'sd5);
    send_item(ACT_POS, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_CLEAR, $urandom(), $urandom());
    send_item(ACT_VEL, 32'd5, 32'd2);
    send_item(ACT_RSVD, $urandom(), $urandom());
    send_item(ACT_VEL, 32'd9, 32'd1);

    // Zero period: the error change is zero and so is the drive.
    wait_idle();
    write_all(32'd5, 32'd4, 32'd3, 16'd0);
    send_item(ACT_VEL, 32'd10, 32'd3);
    send_item(ACT_POS, -32'sd40, 32'd12);
    send_item(ACT_VEL, 32'd1, 32'd0);

    // Largest gains and period, then a period that does not divide evenly.
    wait_idle();
    write_all('1, '1, '1, 16'hFFFF);
    send_item(ACT_VEL, 32'h8000_0000, 32'h0000_0001);
    send_item(ACT_POS, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_VEL, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    write_all(32'd2, 32'd3, 32'd1, 16'd7);
    send_item(ACT_VEL, -32'sd50, 32'd0);
    send_item(ACT_VEL, 32'd33, -32'sd20);
    send_item(ACT_POS, 32'd1000, 32'd999);

    // Random phases, each with its own setting.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       per = 16'hFFFF;
        1:       per = 16'd1;
        2:       per = 16'd0;
        default: per = ($urandom_range(3, 0) == 0) ? PerW'($urandom())
                                                   : PerW'($urandom_range(12, 1));
      endcase
      if (ph == 0) begin
        write_all('1, '1, '1, per);
      end else begin
        write_all(rand_gain(), rand_gain(), rand_gain(), per);
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // Some stretches run with no gaps and no stalls.
        if (n % 50 == 0) begin
          no_idle = ($urandom_range(3, 0) == 0);
        end
        send_random();
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (DrainWait) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("velocity_position_pi_step_unit_tb passed");
    end else begin
      $display("velocity_position_pi_step_unit_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("velocity_position_pi_step_unit_tb failed");
    $finish;
  end

endmodule
